/* sv/sha256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 digest unit.
// No dependencies.
`default_nettype none
package sha256_pkg;

	localparam int BlockBytes = 64;
	localparam int Rounds = 64;
	localparam int QueueDepth = 4;
	localparam logic [7:0] PadByte = 8'h80;

	typedef logic [31:0] word_t;

	// Item passed from the byte collector to the compression engine.
	typedef struct packed {
		logic [511:0] block;  // big-endian block, byte 0 in the top bits
		logic         emit;   // last block of a message: emit digest after it
	} blk_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} eng_state_t;

	typedef enum logic [1:0] {
		FS_COLLECT,
		FS_PAD2
	} fr_state_t;

	function automatic word_t round_k(input logic [5:0] t);
		word_t k [0:63];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
			32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
			32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
			32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
			32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
			32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
			32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
			32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
			32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[t];
	endfunction

	function automatic word_t init_hash(input logic [2:0] i);
		word_t h [0:7];
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return h[i];
	endfunction

	function automatic word_t ror(input word_t v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

endpackage
`default_nettype wire

/* sv/sha256_message_digest_unit.sv */
// Top level of the SHA-256 digest unit: collector, block queue and engine.
// Depends on sha256_pkg, sha256_front, sha256_queue and sha256_engine.
//
//  Channel | Handshake        | Payload
//  input   | valid / ready    | data_byte, has_byte, is_final
//  output  | out_valid / out_ready | digest_word, word_index, last_word
//
// Bytes are taken one per cycle while the block queue has room and no length block is pending.
// The engine takes each 64-byte block through load, 64 rounds and hash add,
// so the sustained rate is about one byte per cycle, set by the round loop.
// A final transfer adds one or two blocks, then eight digest words follow.
// Reset clears control and restores the initial hash; no clearing pass.
`default_nettype none
module sha256_message_digest_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire  [7:0]  data_byte,
	input  wire         has_byte,
	input  wire         is_final,
	input  wire         valid,
	output logic        ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic        out_valid,
	input  wire         out_ready
);
	import sha256_pkg::*;

	blk_item_t f_item, q_item;
	logic      f_valid, f_ready, q_valid, q_ready;

	sha256_front u_front (
		.clk, .arst_n, .data_byte, .has_byte, .is_final, .valid, .ready,
		.blk(f_item), .blk_valid(f_valid), .blk_ready(f_ready)
	);

	sha256_queue u_queue (
		.clk, .arst_n, .wr_item(f_item), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_item(q_item), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	sha256_engine u_engine (
		.clk, .arst_n, .item(q_item), .item_valid(q_valid), .item_ready(q_ready),
		.digest_word, .word_index, .last_word, .out_valid, .out_ready
	);

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last_word does not match word_index");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && word_index != 3'd7) |=>
		(out_valid && word_index == $past(word_index) + 3'd1))
		else $error("digest words out of order");

	a_idx0: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (word_index == 3'd0))
		else $error("digest does not start at h0");

endmodule
`default_nettype wire

/* sv/sha256_front.sv */
// Byte collector and padder: assembles 64-byte blocks and pads the last one.
// Depends on sha256_pkg.
`default_nettype none
module sha256_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire  [7:0]             data_byte,
	input  wire                    has_byte,
	input  wire                    is_final,
	input  wire                    valid,
	output logic                   ready,
	output sha256_pkg::blk_item_t  blk,
	output logic                   blk_valid,
	input  wire                    blk_ready
);
	import sha256_pkg::*;

	logic [7:0]   buf_q [0:BlockBytes-1];
	logic [60:0]  count_q;
	fr_state_t    state_q, state_d;
	logic [63:0]  bits_q;
	logic         wrap_q;

	logic         take;
	logic         wrap;
	logic [5:0]   pos;
	logic [5:0]   fpos;
	logic [60:0]  count_inc;
	logic [60:0]  fcount;
	logic [511:0] cur_blk;
	logic [511:0] pad_blk;
	logic [511:0] len_blk;

	assign pos = count_q[5:0];
	assign count_inc = count_q + 61'd1;
	assign fcount = has_byte ? count_inc : count_q;
	assign fpos = fcount[5:0];
	// This transfer's byte fills the block, so padding starts a fresh block.
	assign wrap = has_byte && pos == 6'd63;

	// Block as it stands after this transfer's byte, padded if final.
	always_comb begin
		for (int i = 0; i < BlockBytes; i++) begin
			logic [7:0] b;
			b = buf_q[i];
			if (has_byte && i == int'(pos)) b = data_byte;
			cur_blk[511-8*i -: 8] = b;
			if (i == int'(fpos)) b = PadByte;
			else if (i > int'(fpos)) b = 8'h00;
			pad_blk[511-8*i -: 8] = b;
		end
		if (fpos < 6'd56) pad_blk[63:0] = {fcount, 3'b000};
		len_blk = {(wrap_q ? PadByte : 8'h00), 440'd0, bits_q};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_COLLECT: if (take && is_final && (wrap || fpos >= 6'd56)) state_d = FS_PAD2;
			FS_PAD2:    if (blk_ready) state_d = FS_COLLECT;
			default:    state_d = FS_COLLECT;
		endcase
	end

	always_comb begin
		ready = 1'b0;
		blk_valid = 1'b0;
		blk.block = cur_blk;
		blk.emit = 1'b0;
		unique case (state_q)
			FS_COLLECT: begin
				// A transfer that completes a block needs queue space.
				if (valid && (is_final || wrap)) begin
					ready = blk_ready;
					blk_valid = 1'b1;
					if (is_final && !wrap) begin
						blk.block = pad_blk;
						blk.emit = (fpos < 6'd56);
					end
				end else begin
					ready = 1'b1;
				end
			end
			FS_PAD2: begin
				blk_valid = 1'b1;
				blk.block = len_blk;
				blk.emit = 1'b1;
			end
			default: ;
		endcase
	end

	assign take = valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_COLLECT;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (take) count_q <= is_final ? 61'd0 : fcount;
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_byte) buf_q[pos] <= data_byte;
		if (take) begin
			bits_q <= {fcount, 3'b000};
			wrap_q <= wrap;
		end
	end

endmodule
`default_nettype wire

/* sv/sha256_queue.sv */
// Small FIFO of padded blocks between the collector and the engine.
// Depends on sha256_pkg.
`default_nettype none
module sha256_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  sha256_pkg::blk_item_t  wr_item,
	input  wire                    wr_valid,
	output logic                   wr_ready,
	output sha256_pkg::blk_item_t  rd_item,
	output logic                   rd_valid,
	input  wire                    rd_ready
);
	import sha256_pkg::*;

	localparam int AW = $clog2(QueueDepth);

	blk_item_t       mem_q [0:QueueDepth-1];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            push, pop;

	assign wr_ready = (cnt_q != (AW+1)'(QueueDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_item = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_item;
	end

endmodule
`default_nettype wire

/* sv/sha256_engine.sv */
// Compression engine: one round per cycle, then hash update and, after a message's last block, digest output.
// Depends on sha256_pkg.
`default_nettype none
module sha256_engine (
	input  wire                    clk,
	input  wire                    arst_n,
	input  sha256_pkg::blk_item_t  item,
	input  wire                    item_valid,
	output logic                   item_ready,
	output logic [31:0]            digest_word,
	output logic [2:0]             word_index,
	output logic                   last_word,
	output logic                   out_valid,
	input  wire                    out_ready
);
	import sha256_pkg::*;

	eng_state_t  state_q, state_d;
	word_t       h_q [0:7];
	word_t       v_q [0:7];
	word_t       w_q [0:15];
	logic [5:0]  t_q;
	logic        emit_q;
	logic [2:0]  idx_q;

	word_t w_new, t1, t2;
	logic  start;

	// The schedule window shifts by one word each round; w_q[0] is W[t].
	assign w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ round_k(t_q) + w_q[0];
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (item_valid) state_d = ST_ROUND;
			ST_ROUND: if (t_q == 6'd63) state_d = ST_ADD;
			ST_ADD:   state_d = emit_q ? ST_EMIT : ST_IDLE;
			ST_EMIT:  if (out_ready && idx_q == 3'd7) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		digest_word = h_q[idx_q];
		word_index = idx_q;
		last_word = (idx_q == 3'd7);
	end

	assign start = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			t_q <= '0;
			idx_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROUND) t_q <= t_q + 6'd1;
			if (state_q == ST_ADD)
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			if (state_q == ST_EMIT && out_ready) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7)
					for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			emit_q <= item.emit;
			for (int i = 0; i < 16; i++) w_q[i] <= item.block[511-32*i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule
`default_nettype wire
